// File: src/gcdb_pkg.sv
// Shared types, widths and constants for the great-circle distance/bearing block.
// Holds the CORDIC arctangent table. No dependencies.
package gcdb_pkg;

	// CORDIC iteration count, shared by the rotation and vectoring pipelines
	localparam int CORDIC_STEPS = 24;

	// Datapath widths
	localparam int TW  = 33;          // Q30 trig values and folded angles
	localparam int AW  = 36;          // unwrapped radian angles
	localparam int ZW  = 35;          // vectoring angle accumulator
	localparam int BW  = 34;          // vectoring input components
	localparam int VW  = 37;          // vectoring x/y datapath
	localparam int RW  = 31;          // square root result
	localparam int SQW = 2 * RW - 1;  // square root operand
	localparam int RDW = 34;          // radians from degree conversion

	typedef logic signed [TW-1:0] trig_t;
	typedef logic signed [AW-1:0] ang_t;
	typedef logic signed [ZW-1:0] zang_t;
	typedef logic signed [BW-1:0] vec_t;
	typedef logic signed [VW-1:0] vw_t;
	typedef logic [RW-1:0] root_t;

	// Q30 angle constants
	localparam ang_t Q_PI      = 36'sd3373259426;
	localparam ang_t Q_HALF_PI = 36'sd1686629713;
	localparam ang_t Q_TWO_PI  = 36'sd6746518852;
	localparam trig_t Q_ONE    = 33'sd1073741824;
	localparam trig_t Q_GAIN   = 33'sd652032874;

	// Degree to radian factor round(pi/180 * 2^40), split at bit K_SPLIT
	localparam int K_SPLIT = 18;
	localparam logic signed [18:0] K_LO = 19'sd108693;
	localparam logic signed [17:0] K_HI = 18'sd73204;

	// Radian to degree factor round(180/pi * 2^24)
	localparam logic signed [30:0] DEG_PER_RAD = 31'sd961263669;
	localparam logic signed [31:0] FULL_TURN   = 32'sd377487360;

	localparam logic [15:0] RADIUS_RESET = 16'd6371;

	// atan(2^-i) in Q30
	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] r;
		case (i)
			0:  r = 32'h3243F6A8;
			1:  r = 32'h1DAC6705;
			2:  r = 32'h0FADBAFC;
			3:  r = 32'h07F56EA6;
			4:  r = 32'h03FEAB76;
			5:  r = 32'h01FFD55B;
			6:  r = 32'h00FFFAAA;
			7:  r = 32'h007FFF55;
			8:  r = 32'h003FFFEA;
			9:  r = 32'h001FFFFD;
			10: r = 32'h000FFFFF;
			11: r = 32'h0007FFFF;
			12: r = 32'h0003FFFF;
			13: r = 32'h0001FFFF;
			14: r = 32'h0000FFFF;
			15: r = 32'h00007FFF;
			16: r = 32'h00003FFF;
			17: r = 32'h00001FFF;
			18: r = 32'h00000FFF;
			19: r = 32'h000007FF;
			20: r = 32'h000003FF;
			21: r = 32'h000001FF;
			22: r = 32'h000000FF;
			23: r = 32'h0000007F;
			24: r = 32'h0000003F;
			25: r = 32'h0000001F;
			26: r = 32'h0000000F;
			27: r = 32'h00000008;
			28: r = 32'h00000004;
			29: r = 32'h00000002;
			30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// File: src/gcdb_sincos.sv
// Pipelined sine/cosine: wrap to [-pi,pi), fold to [-pi/2,pi/2], CORDIC rotation.
// Depends on gcdb_pkg. Accepts one angle per cycle.
module gcdb_sincos (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  gcdb_pkg::ang_t      in_angle,
	output logic                out_valid,
	output gcdb_pkg::trig_t     out_cos,
	output gcdb_pkg::trig_t     out_sin
);

	localparam int N = gcdb_pkg::CORDIC_STEPS;

	gcdb_pkg::ang_t  wrap;
	gcdb_pkg::trig_t ang_s1;
	logic            v_s1;
	gcdb_pkg::ang_t  a_ext;
	gcdb_pkg::ang_t  fold;
	logic            fold_flip;

	gcdb_pkg::trig_t x_s    [0:N];
	gcdb_pkg::trig_t y_s    [0:N];
	gcdb_pkg::trig_t z_s    [0:N];
	logic            flip_s [0:N];
	logic            zero_s [0:N];
	logic            v_s    [0:N];

	// Wrap the angle into [-pi,pi)
	always_comb begin
		if (in_angle >= gcdb_pkg::Q_PI) begin
			wrap = in_angle - gcdb_pkg::Q_TWO_PI;
		end else if (in_angle < -gcdb_pkg::Q_PI) begin
			wrap = in_angle + gcdb_pkg::Q_TWO_PI;
		end else begin
			wrap = in_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ang_s1 <= wrap[gcdb_pkg::TW-1:0];
	end

	// Fold outer half-planes onto the inner one and remember the sign flip
	assign a_ext = gcdb_pkg::ang_t'(ang_s1);

	always_comb begin
		if (a_ext > gcdb_pkg::Q_HALF_PI) begin
			fold      = a_ext - gcdb_pkg::Q_PI;
			fold_flip = 1'b1;
		end else if (a_ext < -gcdb_pkg::Q_HALF_PI) begin
			fold      = a_ext + gcdb_pkg::Q_PI;
			fold_flip = 1'b1;
		end else begin
			fold      = a_ext;
			fold_flip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= gcdb_pkg::Q_GAIN;
		y_s[0]    <= '0;
		z_s[0]    <= fold[gcdb_pkg::TW-1:0];
		flip_s[0] <= fold_flip;
		zero_s[0] <= (ang_s1 == '0);
	end

	// One rotation step per stage
	for (genvar i = 0; i < N; i++) begin : g_rot
		localparam gcdb_pkg::trig_t AT = gcdb_pkg::trig_t'(gcdb_pkg::atan_q30(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - AT;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + AT;
			end
			flip_s[i+1] <= flip_s[i];
			zero_s[i+1] <= zero_s[i];
		end
	end

	// Apply the zero-angle case and the half-plane flip
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (zero_s[N]) begin
			out_cos <= gcdb_pkg::Q_ONE;
			out_sin <= '0;
		end else if (flip_s[N]) begin
			out_cos <= -x_s[N];
			out_sin <= -y_s[N];
		end else begin
			out_cos <= x_s[N];
			out_sin <= y_s[N];
		end
	end

endmodule

// File: src/gcdb_isqrt.sv
// Pipelined exact floor square root, one result bit per stage.
// Depends on gcdb_pkg. Accepts one operand per cycle.
module gcdb_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [gcdb_pkg::SQW-1:0]  in_value,
	output logic                      out_valid,
	output gcdb_pkg::root_t           out_root
);

	localparam int N   = gcdb_pkg::RW;
	localparam int RMW = 2 * N + 1;

	logic [RMW-1:0] rem_s [0:N];
	logic [N-1:0]   res_s [0:N];
	logic           v_s   [0:N];

	// Load the operand as the first remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= RMW'(in_value);
		res_s[0] <= '0;
	end

	// Try each result bit from the top, keep it when the remainder allows
	for (genvar j = 0; j < N; j++) begin : g_bit
		localparam int K = N - 1 - j;
		logic [RMW-1:0] trial;

		assign trial = (RMW'(res_s[j]) << (K + 1)) + (RMW'(1) << (2 * K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (rem_s[j] >= trial) begin
				rem_s[j+1] <= rem_s[j] - trial;
				res_s[j+1] <= res_s[j] | (N'(1) << K);
			end else begin
				rem_s[j+1] <= rem_s[j];
				res_s[j+1] <= res_s[j];
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_root  = res_s[N];

endmodule

// File: src/gcdb_atan2.sv
// Pipelined atan2 by CORDIC vectoring, result in Q30 radians.
// Depends on gcdb_pkg. Accepts one pair per cycle.
module gcdb_atan2 (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  gcdb_pkg::vec_t   in_y,
	input  gcdb_pkg::vec_t   in_x,
	output logic             out_valid,
	output gcdb_pkg::zang_t  out_angle
);

	localparam int N = gcdb_pkg::CORDIC_STEPS;

	gcdb_pkg::vw_t   xe;
	gcdb_pkg::vw_t   ye;
	gcdb_pkg::vw_t   x0;
	gcdb_pkg::vw_t   y0;
	gcdb_pkg::zang_t z0;
	logic            hold0;

	gcdb_pkg::vw_t   x_s    [0:N];
	gcdb_pkg::vw_t   y_s    [0:N];
	gcdb_pkg::zang_t z_s    [0:N];
	logic            hold_s [0:N];
	logic            v_s    [0:N];

	assign xe = gcdb_pkg::vw_t'(in_x);
	assign ye = gcdb_pkg::vw_t'(in_y);

	// Settle the zero-y case and move the left half-plane to the right
	always_comb begin
		x0 = xe;
		y0 = ye;
		if (in_y == '0) begin
			hold0 = 1'b1;
			z0    = (in_x >= 0) ? '0 : gcdb_pkg::zang_t'(gcdb_pkg::Q_PI);
		end else if (in_x < 0) begin
			hold0 = 1'b0;
			z0    = (in_y > 0) ? gcdb_pkg::zang_t'(gcdb_pkg::Q_PI)
			                   : gcdb_pkg::zang_t'(-gcdb_pkg::Q_PI);
			x0    = -xe;
			y0    = -ye;
		end else begin
			hold0 = 1'b0;
			z0    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= x0;
		y_s[0]    <= y0;
		z_s[0]    <= z0;
		hold_s[0] <= hold0;
	end

	// One vectoring step per stage; a settled angle holds
	for (genvar i = 0; i < N; i++) begin : g_vec
		localparam gcdb_pkg::zang_t AT = gcdb_pkg::zang_t'(gcdb_pkg::atan_q30(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (y_s[i] > 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= hold_s[i] ? z_s[i] : z_s[i] + AT;
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= hold_s[i] ? z_s[i] : z_s[i] - AT;
			end
			hold_s[i+1] <= hold_s[i];
		end
	end

	assign out_valid = v_s[N];
	assign out_angle = z_s[N];

endmodule

// File: src/great_circle_distance_bearing.sv
// Haversine great-circle distance and initial bearing between two points.
// Each item passes through the CORDIC rotation, square root and vectoring
// pipelines in series.
// Throughput one item per cycle; busy stays low and results cannot be stalled.
// Reset clears all valid bits and loads the radius register with 6371 km.
// Depends on gcdb_pkg, gcdb_sincos, gcdb_isqrt, gcdb_atan2.
module great_circle_distance_bearing (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [27:0] from_lat,
	input  logic signed [28:0] from_lon,
	input  logic signed [27:0] to_lat,
	input  logic signed [28:0] to_lon,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	output logic               done,
	output logic [31:0]        distance,
	output logic [28:0]        bearing
);

	localparam int SQ_LAT = gcdb_pkg::RW + 1;
	localparam int RDW    = gcdb_pkg::RDW;

	logic [15:0] radius_q;

	logic signed [28:0]    deg_in [4];
	logic signed [47:0]    lo_s1  [4];
	logic signed [46:0]    hi_s1  [4];
	logic                  v_s1;
	logic signed [RDW-1:0] rad_s2 [4];
	logic                  v_s2;
	gcdb_pkg::ang_t        ang_s3 [5];
	logic                  v_s3;

	logic signed [RDW:0]   dphi;
	logic signed [RDW:0]   dlam;

	logic            sc_v [5];
	gcdb_pkg::trig_t sh, sl, c1, s1, c2, s2, cd, sd;
	logic            v_sc;

	logic signed [65:0] p_m1, p_m2, p_m3, p_by, p_t1, p_t2, p_m4, p_t3;
	gcdb_pkg::trig_t m1_s4, m2_s4, m3_s4, by_s4, t1_s4, t2_s4, cd_s4;
	logic            v_s4;
	gcdb_pkg::trig_t m1_s5, m4_s5, by_s5, t1_s5, t3_s5;
	logic            v_s5;
	logic signed [33:0] hav_sum;
	logic [30:0]        hav_s6;
	gcdb_pkg::vec_t     by_s6, bx_s6;
	logic               v_s6;

	gcdb_pkg::vec_t by_d [0:SQ_LAT-1];
	gcdb_pkg::vec_t bx_d [0:SQ_LAT-1];

	logic              sqa_v, sqb_v;
	gcdb_pkg::root_t   ra, rb;
	logic              ata_v, atb_v;
	gcdb_pkg::zang_t   za, zb;

	logic signed [35:0] c_ang;
	logic [33:0]        c_pos;
	logic [49:0]        dp_s7;
	logic signed [65:0] gp_s7;
	logic               v_s7;
	logic [50:0]        dist_rnd;
	logic signed [65:0] deg_rnd;
	logic signed [31:0] deg;
	logic signed [31:0] deg_fix;

	assign busy = 1'b0;

	// Radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= gcdb_pkg::RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// Valid pipe for the front, middle and output stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_sc;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= ata_v & atb_v;
			done <= v_s7;
		end
	end

	assign deg_in[0] = 29'(from_lat);
	assign deg_in[1] = from_lon;
	assign deg_in[2] = 29'(to_lat);
	assign deg_in[3] = to_lon;

	// Degrees to Q30 radians: split constant multiply, then sum and round
	for (genvar k = 0; k < 4; k++) begin : g_d2r
		logic signed [63:0] full;

		assign full = (64'(hi_s1[k]) <<< gcdb_pkg::K_SPLIT) + 64'(lo_s1[k])
			+ 64'sd536870912;

		always_ff @(posedge clk) begin
			lo_s1[k]  <= deg_in[k] * gcdb_pkg::K_LO;
			hi_s1[k]  <= deg_in[k] * gcdb_pkg::K_HI;
			rad_s2[k] <= full[63:30];
		end
	end

	// Form the five angles that feed the sine/cosine units
	assign dphi = (RDW+1)'(rad_s2[2]) - (RDW+1)'(rad_s2[0]);
	assign dlam = (RDW+1)'(rad_s2[3]) - (RDW+1)'(rad_s2[1]);

	always_ff @(posedge clk) begin
		ang_s3[0] <= gcdb_pkg::ang_t'(dphi >>> 1);
		ang_s3[1] <= gcdb_pkg::ang_t'(dlam >>> 1);
		ang_s3[2] <= gcdb_pkg::ang_t'(rad_s2[0]);
		ang_s3[3] <= gcdb_pkg::ang_t'(rad_s2[2]);
		ang_s3[4] <= gcdb_pkg::ang_t'(dlam);
	end

	gcdb_sincos u_sc_hphi (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s3), .in_angle(ang_s3[0]),
		.out_valid(sc_v[0]), .out_cos(), .out_sin(sh)
	);

	gcdb_sincos u_sc_hlam (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s3), .in_angle(ang_s3[1]),
		.out_valid(sc_v[1]), .out_cos(), .out_sin(sl)
	);

	gcdb_sincos u_sc_phi1 (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s3), .in_angle(ang_s3[2]),
		.out_valid(sc_v[2]), .out_cos(c1), .out_sin(s1)
	);

	gcdb_sincos u_sc_phi2 (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s3), .in_angle(ang_s3[3]),
		.out_valid(sc_v[3]), .out_cos(c2), .out_sin(s2)
	);

	gcdb_sincos u_sc_dlam (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s3), .in_angle(ang_s3[4]),
		.out_valid(sc_v[4]), .out_cos(cd), .out_sin(sd)
	);

	assign v_sc = sc_v[0] & sc_v[1] & sc_v[2] & sc_v[3] & sc_v[4];

	// First products of the haversine and bearing terms
	assign p_m1 = sh * sh;
	assign p_m2 = c1 * c2;
	assign p_m3 = sl * sl;
	assign p_by = sd * c2;
	assign p_t1 = c1 * s2;
	assign p_t2 = s1 * c2;

	always_ff @(posedge clk) begin
		m1_s4 <= p_m1[62:30];
		m2_s4 <= p_m2[62:30];
		m3_s4 <= p_m3[62:30];
		by_s4 <= p_by[62:30];
		t1_s4 <= p_t1[62:30];
		t2_s4 <= p_t2[62:30];
		cd_s4 <= cd;
	end

	// Second products
	assign p_m4 = m2_s4 * m3_s4;
	assign p_t3 = t2_s4 * cd_s4;

	always_ff @(posedge clk) begin
		m1_s5 <= m1_s4;
		m4_s5 <= p_m4[62:30];
		by_s5 <= by_s4;
		t1_s5 <= t1_s4;
		t3_s5 <= p_t3[62:30];
	end

	// Sum and clamp the haversine term, form the bearing x component
	assign hav_sum = 34'(m1_s5) + 34'(m4_s5);

	always_ff @(posedge clk) begin
		if (hav_sum < 0) begin
			hav_s6 <= '0;
		end else if (hav_sum > 34'(gcdb_pkg::Q_ONE)) begin
			hav_s6 <= gcdb_pkg::Q_ONE[30:0];
		end else begin
			hav_s6 <= hav_sum[30:0];
		end
		by_s6 <= gcdb_pkg::vec_t'(by_s5);
		bx_s6 <= gcdb_pkg::vec_t'(t1_s5) - gcdb_pkg::vec_t'(t3_s5);
	end

	gcdb_isqrt u_sq_a (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s6),
		.in_value({hav_s6, 30'd0}),
		.out_valid(sqa_v), .out_root(ra)
	);

	gcdb_isqrt u_sq_b (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s6),
		.in_value({gcdb_pkg::Q_ONE[30:0] - hav_s6, 30'd0}),
		.out_valid(sqb_v), .out_root(rb)
	);

	// Hold the bearing components while the square roots run
	always_ff @(posedge clk) begin
		by_d[0] <= by_s6;
		bx_d[0] <= bx_s6;
	end

	for (genvar d = 1; d < SQ_LAT; d++) begin : g_dly
		always_ff @(posedge clk) begin
			by_d[d] <= by_d[d-1];
			bx_d[d] <= bx_d[d-1];
		end
	end

	gcdb_atan2 u_at_dist (
		.clk(clk), .arst_n(arst_n), .in_valid(sqa_v & sqb_v),
		.in_y(gcdb_pkg::vec_t'(ra)), .in_x(gcdb_pkg::vec_t'(rb)),
		.out_valid(ata_v), .out_angle(za)
	);

	gcdb_atan2 u_at_brg (
		.clk(clk), .arst_n(arst_n), .in_valid(sqa_v & sqb_v),
		.in_y(by_d[SQ_LAT-1]), .in_x(bx_d[SQ_LAT-1]),
		.out_valid(atb_v), .out_angle(zb)
	);

	// Scale the central angle by the radius, convert the bearing to degrees
	assign c_ang = {za, 1'b0};
	assign c_pos = (c_ang < 0) ? '0 : c_ang[33:0];

	always_ff @(posedge clk) begin
		dp_s7 <= c_pos * radius_q;
		gp_s7 <= zb * gcdb_pkg::DEG_PER_RAD;
	end

	// Round, saturate and fold into one turn
	assign dist_rnd = 51'(dp_s7) + 51'd32768;
	assign deg_rnd  = gp_s7 + 66'sd8589934592;
	assign deg      = deg_rnd[65:34];

	always_comb begin
		if (deg < 0) begin
			deg_fix = deg + gcdb_pkg::FULL_TURN;
		end else if (deg >= gcdb_pkg::FULL_TURN) begin
			deg_fix = deg - gcdb_pkg::FULL_TURN;
		end else begin
			deg_fix = deg;
		end
	end

	always_ff @(posedge clk) begin
		if (dist_rnd[50:48] != 3'd0) begin
			distance <= 32'hFFFF_FFFF;
		end else begin
			distance <= dist_rnd[47:16];
		end
		bearing <= deg_fix[28:0];
	end

endmodule
